FILE: design/htq_pkg.sv
package htq_pkg;

  localparam int GRID_VERTS_SIDE = 64;  // vertices along each side of the grid

  localparam int HEIGHT_W  = 32;
  localparam int COORD_W   = 32;
  localparam int VIDX_W    = 6;
  localparam int TSIZE_W   = 24;
  localparam int TILES_W   = 6;
  localparam int TILE_W    = 8;   // tile index, wide enough for 256 vertices a side
  localparam int FRAC_W    = 17;  // Q0.16 plus one bit to hold 1.0
  localparam int QUOT_W    = COORD_W + 16;
  localparam int DIV_STAGES = QUOT_W;

  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_TILES = 1'b1;

  typedef struct packed {
    logic [TSIZE_W-1:0] r;
    logic [QUOT_W-1:0]  dq;
  } div_st_t;

  typedef struct packed {
    logic                 kind;
    logic [VIDX_W-1:0]    vertex_col;
    logic [VIDX_W-1:0]    vertex_row;
    logic [HEIGHT_W-1:0]  height_value;
  } front_meta_t;

  typedef struct packed {
    logic              ok;
    logic [TILE_W-1:0] tile;
    logic [FRAC_W-1:0] frac;
  } loc_t;

  typedef struct packed {
    logic                 kind;
    logic                 oor;
    logic [TILE_W-1:0]    tx;
    logic [TILE_W-1:0]    tz;
    logic [FRAC_W-1:0]    fx;
    logic [FRAC_W-1:0]    fz;
    logic [VIDX_W-1:0]    vertex_col;
    logic [VIDX_W-1:0]    vertex_row;
    logic [HEIGHT_W-1:0]  height_value;
  } htq_entry_t;

  // one restoring step: one quotient bit
  function automatic div_st_t div_step(div_st_t s, logic [TSIZE_W-1:0] ts);
    logic [TSIZE_W:0] r2;
    div_st_t o;
    r2 = {s.r, s.dq[QUOT_W-1]};
    o.dq = {s.dq[QUOT_W-2:0], 1'b0};
    if (r2 >= {1'b0, ts}) begin
      o.r = TSIZE_W'(r2 - {1'b0, ts});
      o.dq[0] = 1'b1;
    end else begin
      o.r = r2[TSIZE_W-1:0];
    end
    return o;
  endfunction

  // quotient of (c << 16) / ts: upper bits are the tile, lower the fraction
  function automatic loc_t locate(logic [QUOT_W-1:0] q, logic [TSIZE_W-1:0] r,
                                  logic [TILE_W-1:0] n);
    logic [COORD_W-1:0] t;
    logic [15:0] f;
    loc_t o;
    t = q[QUOT_W-1:16];
    f = q[15:0];
    if (t < COORD_W'(n)) begin
      o.ok = 1'b1;
      o.tile = t[TILE_W-1:0];
      o.frac = {1'b0, f};
    end else if (t == COORD_W'(n) && f == '0 && r == '0) begin
      o.ok = 1'b1;
      o.tile = n - 1'b1;
      o.frac = FRAC_ONE;
    end else begin
      o.ok = 1'b0;
      o.tile = '0;
      o.frac = '0;
    end
    return o;
  endfunction

endpackage

FILE: design/htq_if.sv
interface htq_item_if;
  import htq_pkg::*;
  logic                valid;
  logic                ready;
  logic                kind;
  logic [VIDX_W-1:0]   vertex_col;
  logic [VIDX_W-1:0]   vertex_row;
  logic [HEIGHT_W-1:0] height_value;
  logic [COORD_W-1:0]  query_x;
  logic [COORD_W-1:0]  query_z;
  modport source (output valid, kind, vertex_col, vertex_row, height_value, query_x,
                  query_z, input ready);
  modport sink (input valid, kind, vertex_col, vertex_row, height_value, query_x,
                query_z, output ready);
endinterface

interface htq_result_if;
  import htq_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;
  logic                out_of_range;
  modport source (output valid, height, out_of_range, input ready);
  modport sink (input valid, height, out_of_range, output ready);
endinterface

interface htq_cfg_if;
  import htq_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [TSIZE_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

FILE: design/htq_front.sv
module htq_front (
  input  logic                       clk,
  input  logic                       rst,
  htq_item_if.sink                   item,
  input  logic [htq_pkg::TSIZE_W-1:0] ts,
  input  logic [htq_pkg::TILE_W-1:0]  n,
  input  logic                       q_full,
  output logic                       push,
  output htq_pkg::htq_entry_t        push_entry
);
  import htq_pkg::*;

  localparam int L = DIV_STAGES;

  logic [L-1:0] v;
  front_meta_t  meta [L];
  div_st_t      sx [L];
  div_st_t      sz [L];
  logic         en;
  div_st_t      x0, z0;
  loc_t         lx, lz;

  assign en = !v[L-1] || !q_full;
  assign item.ready = en;
  assign push = v[L-1] && !q_full;

  assign x0 = '{r: '0, dq: {item.query_x, 16'h0}};
  assign z0 = '{r: '0, dq: {item.query_z, 16'h0}};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[L-2:0], item.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      meta[0] <= '{kind: item.kind, vertex_col: item.vertex_col,
                   vertex_row: item.vertex_row, height_value: item.height_value};
      sx[0] <= div_step(x0, ts);
      sz[0] <= div_step(z0, ts);
      for (int i = 1; i < L; i++) begin
        meta[i] <= meta[i-1];
        sx[i] <= div_step(sx[i-1], ts);
        sz[i] <= div_step(sz[i-1], ts);
      end
    end
  end

  always_comb begin
    lx = locate(sx[L-1].dq, sx[L-1].r, n);
    lz = locate(sz[L-1].dq, sz[L-1].r, n);
    push_entry.kind = meta[L-1].kind;
    push_entry.oor = !(lx.ok && lz.ok);
    push_entry.tx = lx.tile;
    push_entry.tz = lz.tile;
    push_entry.fx = lx.frac;
    push_entry.fz = lz.frac;
    push_entry.vertex_col = meta[L-1].vertex_col;
    push_entry.vertex_row = meta[L-1].vertex_row;
    push_entry.height_value = meta[L-1].height_value;
  end

endmodule

FILE: design/htq_queue.sv
module htq_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  htq_pkg::htq_entry_t push_entry,
  input  logic                pop,
  output htq_pkg::htq_entry_t head,
  output logic                full,
  output logic                empty
);
  import htq_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW = $clog2(DEPTH);

  htq_entry_t     q [DEPTH];
  logic [PW-1:0]  wp, rp;
  logic [PW:0]    cnt;

  assign full = cnt == (PW+1)'(DEPTH);
  assign empty = cnt == '0;
  assign head = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      if (push && !pop) cnt <= cnt + 1'b1;
      else if (pop && !push) cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q[wp] <= push_entry;
  end

endmodule

FILE: design/htq_back.sv
module htq_back (
  input  logic                clk,
  input  logic                rst,
  input  htq_pkg::htq_entry_t head,
  input  logic                empty,
  output logic                pop,
  htq_result_if.source        result
);
  import htq_pkg::*;

  localparam int S = GRID_VERTS_SIDE;
  localparam int HALF = (S + 1) / 2;
  localparam int BDEPTH = HALF * HALF;
  localparam int AW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
  localparam int TW = $clog2(S);
  localparam int PROD_W = HEIGHT_W + 1 + FRAC_W + 1;
  localparam int SUM_W = HEIGHT_W + 4;

  logic en;
  logic [AW-1:0] raddr [4];
  logic [AW-1:0] waddr;
  logic [1:0]    wbank;
  logic          wen;
  logic [TW-1:0] txs, tzs, txp, tzp;

  // stage 1: bank reads
  logic                v1, oor1, tx0, tz0;
  logic [FRAC_W-1:0]   fx1, fz1;
  logic [HEIGHT_W-1:0] rd [4];
  // stage 2: products
  logic                v2, oor2;
  logic [HEIGHT_W-1:0] base2;
  logic signed [PROD_W-1:0] p1, p2;
  // output register
  logic                rv, roor;
  logic [HEIGHT_W-1:0] rh;

  assign en = !rv || result.ready;
  assign pop = !empty && en;

  // banks by (row, col) parity: the four corners of a tile land in four banks
  always_comb begin
    int c, r;
    txs = head.tx[TW-1:0];
    tzs = head.tz[TW-1:0];
    txp = txs + 1'b1;
    tzp = tzs + 1'b1;
    for (int b = 0; b < 4; b++) begin
      c = (txs[0] == b[0]) ? int'(txs) : int'(txp);
      r = (tzs[0] == b[1]) ? int'(tzs) : int'(tzp);
      raddr[b] = AW'((r >> 1) * HALF + (c >> 1));
    end
    wbank = {head.vertex_row[0], head.vertex_col[0]};
    waddr = AW'((int'(head.vertex_row) >> 1) * HALF + (int'(head.vertex_col) >> 1));
    wen = pop && head.kind == KIND_WRITE &&
          int'(head.vertex_col) < S && int'(head.vertex_row) < S;
  end

  for (genvar b = 0; b < 4; b++) begin : g_bank
    logic [HEIGHT_W-1:0] mem [BDEPTH];
    always_ff @(posedge clk) begin
      if (wen && wbank == 2'(b)) mem[waddr] <= head.height_value;
      if (en) rd[b] <= mem[raddr[b]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      rv <= 1'b0;
    end else if (en) begin
      v1 <= pop && head.kind == KIND_QUERY;
      v2 <= v1;
      rv <= v2;
    end
  end

  // stage 2 math: pick triangle, differences, two multiplies
  logic lower;
  logic signed [HEIGHT_W:0] hbl, hbr, htl, htr, d1, d2;
  logic [FRAC_W-1:0] m1, m2;
  logic [HEIGHT_W-1:0] base;
  always_comb begin
    hbl = {rd[{tz0, tx0}][HEIGHT_W-1], rd[{tz0, tx0}]};
    hbr = {rd[{tz0, ~tx0}][HEIGHT_W-1], rd[{tz0, ~tx0}]};
    htl = {rd[{~tz0, tx0}][HEIGHT_W-1], rd[{~tz0, tx0}]};
    htr = {rd[{~tz0, ~tx0}][HEIGHT_W-1], rd[{~tz0, ~tx0}]};
    lower = ({1'b0, fx1} + {1'b0, fz1}) < {1'b0, FRAC_ONE};
    if (lower) begin
      base = rd[{tz0, tx0}];
      d1 = hbr - hbl;
      d2 = htl - hbl;
      m1 = fx1;
      m2 = fz1;
    end else begin
      base = rd[{~tz0, ~tx0}];
      d1 = htl - htr;
      d2 = hbr - htr;
      m1 = FRAC_ONE - fx1;
      m2 = FRAC_ONE - fz1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (pop) begin
        oor1 <= head.oor;
        tx0 <= head.tx[0];
        tz0 <= head.tz[0];
        fx1 <= head.fx;
        fz1 <= head.fz;
      end
      oor2 <= oor1;
      base2 <= base;
      // operands sign-extended to full product width before the multiply
      p1 <= PROD_W'(d1) * PROD_W'($signed({1'b0, m1}));
      p2 <= PROD_W'(d2) * PROD_W'($signed({1'b0, m2}));
    end
  end

  // stage 3: floor-shift, sum, saturate
  logic signed [SUM_W-1:0] sum;
  logic [HEIGHT_W-1:0] hsat;
  always_comb begin
    sum = SUM_W'($signed(base2)) + SUM_W'(p1 >>> 16) + SUM_W'(p2 >>> 16);
    if (sum > SUM_W'($signed({1'b0, {(HEIGHT_W-1){1'b1}}})))
      hsat = {1'b0, {(HEIGHT_W-1){1'b1}}};
    else if (sum < -(SUM_W'(1) <<< (HEIGHT_W-1)))
      hsat = {1'b1, {(HEIGHT_W-1){1'b0}}};
    else
      hsat = sum[HEIGHT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      roor <= oor2;
      rh <= oor2 ? '0 : hsat;
    end
  end

  assign result.valid = rv;
  assign result.height = rh;
  assign result.out_of_range = roor;

endmodule

FILE: design/heightmap_triangle_height_query_unit.sv
// Heightmap triangle height query unit.
// Channels: item (sink) carries vertex writes (kind 0) and height queries
// (kind 1); result (source) returns one transaction per query, none per
// write; cfg (sink, always ready) writes the tile edge length (index 0) and
// grid_tiles (index 1); the user must do so only while the unit is idle, as
// the block does not enforce it. Throughput: one item per cycle while
// item.ready is high. A query passes the 48-stage divider pipeline of the
// front (the accepting edge loads its first stage), one register in the
// queue, one bank read, one multiply stage and the output register.
// Heights sit in four parity banks, one read port each, so all four
// corners of a tile are fetched in the same cycle.
// Reset clears control state and sets the tile length to 1.0, grid_tiles
// to 63; heights are undefined until written and need no clearing pass.
// When the receiver stalls the back end holds its stages, the queue fills,
// then the front holds and item.ready drops. Writes and queries pass the
// same pipe, so a query sees every write accepted before it.
module heightmap_triangle_height_query_unit (
  input logic          clk,
  input logic          rst,
  htq_item_if.sink     item,
  htq_result_if.source result,
  htq_cfg_if.sink      cfg
);
  import htq_pkg::*;

  logic [TSIZE_W-1:0] tile_len;
  logic [TILES_W-1:0] grid_tiles;
  logic [TSIZE_W-1:0] ts_eff;
  logic [TILE_W-1:0]  n_eff;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tile_len <= TSIZE_W'(65536);
      grid_tiles <= TILES_W'(63);
    end else if (cfg.valid) begin
      if (cfg.index == REG_TILE_SIZE) tile_len <= cfg.data;
      if (cfg.index == REG_GRID_TILES) grid_tiles <= cfg.data[TILES_W-1:0];
    end
  end

  // zero tile size acts as one; tile count clamped to 1 .. side - 1
  always_comb begin
    ts_eff = (tile_len == '0) ? TSIZE_W'(1) : tile_len;
    if (grid_tiles == '0)
      n_eff = TILE_W'(1);
    else if (int'(grid_tiles) > GRID_VERTS_SIDE - 1)
      n_eff = TILE_W'(GRID_VERTS_SIDE - 1);
    else
      n_eff = TILE_W'(grid_tiles);
  end

  logic       push, pop, q_full, q_empty;
  htq_entry_t push_entry, head;

  htq_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .ts         (ts_eff),
    .n          (n_eff),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  htq_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  htq_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .empty  (q_empty),
    .pop    (pop),
    .result (result)
  );

endmodule

FILE: tb/htq_height_checker.sv
module htq_height_checker
  import htq_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  htq_item_if   item,
  htq_result_if result,
  htq_cfg_if    cfg,
  output int    fails,
  output int    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [HEIGHT_W-1:0] height;
    logic                oor;
  } height_exp_t;

  logic [HEIGHT_W-1:0] vert_h [64*64];
  logic [TSIZE_W-1:0]  tile_sz;
  logic [TILES_W-1:0]  tiles;
  height_exp_t         exp_q [$];

  // tile index and Q0.16 fraction (65536 at the far edge); 0 return means beyond the grid
  function automatic bit find_tile(longint c, longint ts, longint n,
                                   output longint tile, output longint frac);
    longint t, rem;
    t = c / ts;
    rem = c - t * ts;
    tile = 0;
    frac = 0;
    if (t < n) begin
      tile = t;
      frac = (rem << 16) / ts;
      return 1;
    end
    if (t == n && rem == 0) begin
      tile = n - 1;
      frac = 65536;
      return 1;
    end
    return 0;
  endfunction

  function automatic longint vert_at(longint col, longint row);
    return longint'($signed(vert_h[row*64 + col]));
  endfunction

  function automatic height_exp_t interp_height(logic [COORD_W-1:0] qx,
                                                logic [COORD_W-1:0] qz);
    height_exp_t e;
    longint ts, n, tx, tz, fx, fz, bl, br, tl, tr, h;
    ts = (tile_sz == 0) ? 1 : longint'(tile_sz);
    n = (tiles == 0) ? 1 : longint'(tiles);
    if (n > 63) n = 63;
    e.height = '0;
    e.oor = 1'b1;
    if (!find_tile(longint'(qx), ts, n, tx, fx)) return e;
    if (!find_tile(longint'(qz), ts, n, tz, fz)) return e;
    bl = vert_at(tx, tz);
    br = vert_at(tx + 1, tz);
    tl = vert_at(tx, tz + 1);
    tr = vert_at(tx + 1, tz + 1);
    // >>> on signed longint floors, matching truncation of products
    if (fx + fz < 65536)
      h = bl + (((br - bl) * fx) >>> 16) + (((tl - bl) * fz) >>> 16);
    else
      h = tr + (((tl - tr) * (65536 - fx)) >>> 16) + (((br - tr) * (65536 - fz)) >>> 16);
    if (h > 64'sd2147483647) h = 64'sd2147483647;
    if (h < -64'sd2147483648) h = -64'sd2147483648;
    e.height = h[31:0];
    e.oor = 1'b0;
    return e;
  endfunction

  assign pending = exp_q.size();

  always @(posedge clk) begin
    height_exp_t e;
    int nerr;
    if (rst) begin
      tile_sz <= 24'd65536;
      tiles <= 6'd63;
      exp_q.delete();
      fails <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == REG_TILE_SIZE) tile_sz <= cfg.data;
        else if (cfg.index == REG_GRID_TILES) tiles <= cfg.data[TILES_W-1:0];
      end
      if (item.valid && item.ready) begin
        if (item.kind == KIND_WRITE)
          vert_h[{item.vertex_row, item.vertex_col}] <= item.height_value;
        else
          exp_q.insert(exp_q.size(), interp_height(item.query_x, item.query_z));
      end
      if (result.valid && result.ready) begin
        nerr = 0;
        if (exp_q.size() == 0) begin
          $error("unexpected result transaction height %0d", $signed(result.height));
          nerr = 1;
        end else begin
          e = exp_q.pop_front();
          if (result.height !== e.height) begin
            $error("height expected %0d actual %0d", $signed(e.height),
                   $signed(result.height));
            nerr++;
          end
          if (result.out_of_range !== e.oor) begin
            $error("out_of_range expected %0b actual %0b", e.oor, result.out_of_range);
            nerr++;
          end
        end
        if (nerr != 0) fails <= fails + nerr;
      end
    end
  end
endmodule

FILE: tb/tb_heightmap_triangle_height_query_unit.sv
module tb_heightmap_triangle_height_query_unit;
  import htq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst;
  int   fails, pending;

  // sender / receiver idle percentages, set per phase
  int   snd_idle, rcv_idle;
  // toggled by stimulus to ask the receiver for a long hold-off
  bit   hold_req;

  // current effective config, mirrored for stimulus shaping
  longint eff_ts, eff_n;

  htq_item_if   item ();
  htq_result_if result ();
  htq_cfg_if    cfg ();

  heightmap_triangle_height_query_unit dut (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg)
  );

  htq_height_checker chk (
    .clk(clk), .rst(rst), .item(item), .result(result), .cfg(cfg),
    .fails(fails), .pending(pending)
  );

  always #6 clk = ~clk;

  // watchdog: far above the slowest legal run
  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stalls, plus a long counted hold-off on request
  initial begin
    bit last_req;
    int hold_left;
    last_req = 1'b0;
    hold_left = 0;
    result.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != last_req) begin
        last_req = hold_req;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        result.ready <= 1'b0;
      end else begin
        result.ready <= ($urandom_range(0, 99) >= rcv_idle);
      end
    end
  end

  // one item transaction; random gap before it per sender idle rate
  task automatic send_item(logic k, logic [5:0] col, logic [5:0] row,
                           logic [31:0] hv, logic [31:0] qx, logic [31:0] qz);
    while ($urandom_range(0, 99) < snd_idle) begin
      item.valid <= 1'b0;
      @(posedge clk);
    end
    item.valid <= 1'b1;
    item.kind <= k;
    item.vertex_col <= col;
    item.vertex_row <= row;
    item.height_value <= hv;
    item.query_x <= qx;
    item.query_z <= qz;
    do @(posedge clk); while (!item.ready);
  endtask

  task automatic put_vertex(logic [5:0] col, logic [5:0] row, logic [31:0] hv);
    send_item(KIND_WRITE, col, row, hv, $urandom, $urandom);
  endtask

  task automatic query(logic [31:0] qx, logic [31:0] qz);
    send_item(KIND_QUERY, 6'($urandom), 6'($urandom), $urandom, qx, qz);
  endtask

  // drop valid, wait out every result plus the pipe depth for trailing writes
  task automatic drain();
    item.valid <= 1'b0;
    cfg.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TSIZE_W-1:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_grid(logic [TSIZE_W-1:0] ts, logic [TILES_W-1:0] n);
    write_reg(REG_TILE_SIZE, ts);
    write_reg(REG_GRID_TILES, n);
    eff_ts = (ts == 0) ? 1 : longint'(ts);
    eff_n = (n == 0) ? 1 : longint'(n);
    if (eff_n > 63) eff_n = 63;
  endtask

  // coordinate mostly inside the grid, with far edge, just past it, tile boundaries and noise
  function automatic logic [31:0] pick_coord();
    longint ext;
    int r;
    ext = eff_ts * eff_n;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom;
    if (r == 1) return ext[31:0];
    if (r == 2) return 32'(ext + $urandom_range(1, 3));
    if (r == 3) return 32'(longint'($urandom_range(0, 32'(eff_n - 1))) * eff_ts);
    return $urandom_range(0, 32'(ext - 1));
  endfunction

  function automatic logic [31:0] pick_height();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return $urandom;
      default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
    endcase
  endfunction

  task automatic random_items(int count, bit with_hold);
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 3) hold_req = ~hold_req;
      if ($urandom_range(0, 3) == 0)
        put_vertex(6'($urandom), 6'($urandom), pick_height());
      else
        query(pick_coord(), pick_coord());
    end
  endtask

  initial begin
    logic [TSIZE_W-1:0] ts_list [6];
    logic [TILES_W-1:0] n_list [6];
    rst <= 1'b1;
    hold_req = 1'b0;
    snd_idle = 8;
    rcv_idle = 51;
    eff_ts = 65536;
    eff_n = 63;
    item.valid <= 1'b0;
    item.kind <= KIND_WRITE;
    item.vertex_col <= '0;
    item.vertex_row <= '0;
    item.height_value <= '0;
    item.query_x <= '0;
    item.query_z <= '0;
    cfg.valid <= 1'b0;
    cfg.index <= REG_TILE_SIZE;
    cfg.data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // heights are undefined until written: load rows and columns 0..31, plus
    // the far corner block; every query below reads only those vertices
    for (int r = 0; r < 32; r++)
      for (int c = 0; c < 32; c++)
        put_vertex(c[5:0], r[5:0], pick_height());
    put_vertex(6'd63, 6'd63, 32'h7FFF_FFFF);
    put_vertex(6'd62, 6'd63, 32'h8000_0000);
    put_vertex(6'd63, 6'd62, 32'h8000_0000);
    put_vertex(6'd62, 6'd62, 32'h7FFF_FFFF);

    // directed: reset grid, corners, far edge, past edge, diagonal, extremes
    query(32'd0, 32'd0);
    query(32'h003F_0000, 32'h003F_0000);
    query(32'h003F_0001, 32'd5);
    query(32'd5, 32'h003F_0001);
    query(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query(32'h0000_8000, 32'h0000_8000);
    query(32'h0001_4000, 32'h0001_C000);
    query(32'h0001_3FFF, 32'h0001_C000);
    query(32'h001E_FFFF, 32'h001D_0001);
    query(32'h003E_FFFF, 32'h003E_FFFF);
    query(32'h003E_0001, 32'h003E_8000);
    query(32'h003F_0000, 32'h003E_8000);
    put_vertex(6'd0, 6'd0, 32'h8000_0000);
    put_vertex(6'd1, 6'd0, 32'h7FFF_FFFF);
    query(32'h0000_FFFF, 32'd0);
    drain();

    // tiny tile, one tile, zero treated as one, widest tile, middle value
    ts_list = '{24'd1, 24'd0, 24'hFF_FFFF, 24'd200_000, 24'd65536, 24'd777};
    n_list  = '{6'd1, 6'd0, 6'd31, 6'd5, 6'd31, 6'd20};
    set_grid(ts_list[0], n_list[0]);
    query(32'd0, 32'd1);
    query(32'd1, 32'd1);
    query(32'd2, 32'd0);

    for (int p = 0; p < 6; p++) begin
      if (p < 2) begin
        snd_idle = 8;
        rcv_idle = 51;
      end else if (p < 4) begin
        snd_idle = 51;
        rcv_idle = 8;
      end else begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      drain();
      set_grid(ts_list[p], n_list[p]);
      random_items(135, p == 1 || p == 4);
    end
    drain();

    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
